// File: hw/rtl/seam_smoothness_cost_top_defines.svh
// ----------------------------------------------------------------------------
// Seam smoothness cost assertion macros
// Shared property wrappers for the seam cost block.
// ----------------------------------------------------------------------------
`ifndef SEAM_SMOOTHNESS_COST_TOP_DEFINES_SVH
`define SEAM_SMOOTHNESS_COST_TOP_DEFINES_SVH

// Implication in the same cycle, held off during reset.
`define SSC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the next cycle, held off during reset.
`define SSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ssc_pkg.sv
// ----------------------------------------------------------------------------
// Seam smoothness cost package
// Shared types, mode codes and per-stage step functions.
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

    localparam int RadW  = 22;
    localparam int RootW = 11;
    localparam int DenW  = 11;

    typedef enum logic [1:0] {
        SSC_MODE_COLOUR = 2'd0,
        SSC_MODE_GRAD   = 2'd1,
        SSC_MODE_BOTH   = 2'd2,
        SSC_MODE_EDGE   = 2'd3
    } t_cost_mode;

    typedef struct packed {
        logic [RadW-1:0]  rem;
        logic [RootW-1:0] root;
    } t_sq_state;

    typedef struct packed {
        logic [DenW-1:0] rem;
        logic [RadW-1:0] num;
        logic [RadW-1:0] quo;
        logic [DenW-1:0] den;
    } t_div_state;

    // One root bit: try root + 2^k against the running remainder.
    function automatic t_sq_state isqrt_step(t_sq_state st, int k);
        logic [23:0] trial;
        t_sq_state   nx;
        trial = ({13'd0, st.root} << (k + 1)) + (24'd1 << (2 * k));
        nx = st;
        if ({2'b00, st.rem} >= trial) begin
            nx.rem  = st.rem - trial[RadW-1:0];
            nx.root = st.root | (11'd1 << k);
        end
        return nx;
    endfunction

    // One quotient bit of a restoring division.
    function automatic t_div_state div_step(t_div_state st);
        logic [DenW:0] sh;
        logic [DenW:0] diff;
        t_div_state    nx;
        sh   = {st.rem, st.num[RadW-1]};
        diff = sh - {1'b0, st.den};
        nx = st;
        nx.num = {st.num[RadW-2:0], 1'b0};
        if (sh >= {1'b0, st.den}) begin
            nx.rem = diff[DenW-1:0];
            nx.quo = {st.quo[RadW-2:0], 1'b1};
        end else begin
            nx.rem = sh[DenW-1:0];
            nx.quo = {st.quo[RadW-2:0], 1'b0};
        end
        return nx;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ssc_in_if.sv
// ----------------------------------------------------------------------------
// Seam cost input channel
// Valid/ready channel carrying one neighbour pair item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssc_in_if;
    logic        valid;
    logic        ready;
    logic        same_label;
    logic        horizontal_pair;
    logic [23:0] colour_p_first;
    logic [23:0] colour_p_second;
    logic [23:0] colour_q_first;
    logic [23:0] colour_q_second;
    logic [47:0] grad_p_first;
    logic [47:0] grad_p_second;
    logic [47:0] grad_q_first;
    logic [47:0] grad_q_second;

    modport source (
        output valid, same_label, horizontal_pair,
        output colour_p_first, colour_p_second, colour_q_first, colour_q_second,
        output grad_p_first, grad_p_second, grad_q_first, grad_q_second,
        input  ready
    );
    modport sink (
        input  valid, same_label, horizontal_pair,
        input  colour_p_first, colour_p_second, colour_q_first, colour_q_second,
        input  grad_p_first, grad_p_second, grad_q_first, grad_q_second,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/ssc_out_if.sv
// ----------------------------------------------------------------------------
// Seam cost output channel
// Valid/ready channel carrying one seam cost item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssc_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] seam_cost;

    modport source (output valid, seam_cost, input ready);
    modport sink   (input valid, seam_cost, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ssc_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floored root of a 22-bit radicand, one root bit per stage, 11 stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [21:0] i_rad,
    output logic      [10:0] o_root
);

    ssc_pkg::t_sq_state r_st [0:10];

    for (genvar g = 0; g < 11; g++) begin : g_stage
        if (g == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[g] <= ssc_pkg::isqrt_step('{rem: i_rad, root: 11'd0}, 10 - g);
                end
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[g] <= ssc_pkg::isqrt_step(r_st[g-1], 10 - g);
                end
            end
        end
    end

    assign o_root = r_st[10].root;

endmodule

`default_nettype wire

// File: hw/rtl/ssc_div.sv
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring division of a 22-bit value by an 11-bit value, one bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_div (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [21:0] i_num,
    input  wire logic [10:0] i_den,
    output logic      [21:0] o_quo
);

    ssc_pkg::t_div_state r_st [0:21];

    for (genvar g = 0; g < 22; g++) begin : g_stage
        if (g == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[g] <= ssc_pkg::div_step(
                        '{rem: 11'd0, num: i_num, quo: 22'd0, den: i_den});
                end
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[g] <= ssc_pkg::div_step(r_st[g-1]);
                end
            end
        end
    end

    assign o_quo = r_st[21].quo;

endmodule

`default_nettype wire

// File: hw/rtl/ssc_dist_lane.sv
// ----------------------------------------------------------------------------
// Triple distance lane
// Floored Euclidean distance between two packed 8-bit triples.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_dist_lane (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [23:0] i_a,
    input  wire logic [23:0] i_b,
    output logic      [8:0]  o_dist
);

    logic [17:0] r_sq;
    logic [17:0] n_sq;
    logic [10:0] w_root;

    always_comb begin
        logic [7:0]  d;
        logic [15:0] p;
        n_sq = '0;
        for (int k = 0; k < 3; k++) begin
            d = (i_a[8*k +: 8] > i_b[8*k +: 8]) ? i_a[8*k +: 8] - i_b[8*k +: 8]
                                                : i_b[8*k +: 8] - i_a[8*k +: 8];
            p = d * d;
            n_sq = n_sq + {2'b00, p};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= n_sq;
        end
    end

    ssc_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_rad  ({4'd0, r_sq}),
        .o_root (w_root)
    );

    assign o_dist = w_root[8:0];

endmodule

`default_nettype wire

// File: hw/rtl/seam_smoothness_cost_top.sv
// ----------------------------------------------------------------------------
// Seam smoothness cost
// Pairwise seam cost between neighbouring pixels labelled from two images.
// ----------------------------------------------------------------------------
// Takes one neighbour pair item per cycle unless the output stalls and returns
// one seam cost item for each, in order. Four distance lanes (colour at p,
// colour at q, gradient at p, gradient at q) run side by side, each a square
// sum and bit-per-stage root; a merge stage adds their results, then the edge
// path runs a 22-stage divider and an 11-stage root, and the output register
// picks the cost by mode. The whole pipeline advances together: ready is high
// whenever the output register is empty or its item is being taken, so a
// stalled output freezes every stage and nothing is lost.
// Write cost_mode only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "seam_smoothness_cost_top_defines.svh"

module seam_smoothness_cost_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_wdata,
    ssc_in_if.sink           i_item,
    ssc_out_if.source        o_item
);

    typedef struct packed {
        logic        same;
        logic [10:0] s;
    } t_pre;

    typedef struct packed {
        logic       same;
        logic       szero;
        logic [9:0] e;
        logic [9:0] g;
    } t_post;

    ssc_pkg::t_cost_mode r_cost_mode;

    logic        w_en;
    logic [23:0] w_gp_first, w_gp_second, w_gq_first, w_gq_second;
    logic [10:0] w_s;
    logic [8:0]  w_dc_p, w_dc_q, w_dg_p, w_dg_q;
    logic [21:0] w_quo;
    logic [10:0] w_root;

    // Lane-side delay line.
    logic  r_vld_a [0:11];
    t_pre  r_pre   [0:11];

    // Merge stage.
    logic        r_m_vld;
    logic        r_m_same;
    logic [9:0]  r_m_e;
    logic [9:0]  r_m_g;
    logic [21:0] r_m_num;
    logic [10:0] r_m_s;
    logic [9:0]  w_e;
    logic [19:0] w_ee;

    // Divider/root-side delay line.
    logic  r_vld_b [0:32];
    t_post r_post  [0:32];

    // Output register.
    logic        r_out_vld;
    logic [10:0] r_out_cost;
    logic [10:0] n_out_cost;

    // Advance the whole pipeline unless the output item is stuck.
    assign w_en         = !r_out_vld || o_item.ready;
    assign i_item.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cost_mode <= ssc_pkg::SSC_MODE_COLOUR;
        end else if (i_cfg_we) begin
            r_cost_mode <= ssc_pkg::t_cost_mode'(i_cfg_wdata);
        end
    end

    // Pick y gradient triples for horizontal pairs, x otherwise.
    assign w_gp_first  = i_item.horizontal_pair ? i_item.grad_p_first[47:24]
                                                : i_item.grad_p_first[23:0];
    assign w_gp_second = i_item.horizontal_pair ? i_item.grad_p_second[47:24]
                                                : i_item.grad_p_second[23:0];
    assign w_gq_first  = i_item.horizontal_pair ? i_item.grad_q_first[47:24]
                                                : i_item.grad_q_first[23:0];
    assign w_gq_second = i_item.horizontal_pair ? i_item.grad_q_second[47:24]
                                                : i_item.grad_q_second[23:0];

    // Edge strength: six gradient channels at p.
    assign w_s = {3'd0, w_gp_first[7:0]}  + {3'd0, w_gp_first[15:8]}
               + {3'd0, w_gp_first[23:16]} + {3'd0, w_gp_second[7:0]}
               + {3'd0, w_gp_second[15:8]} + {3'd0, w_gp_second[23:16]};

    ssc_dist_lane u_lane_cp (
        .i_clk (i_clk), .i_en (w_en),
        .i_a (i_item.colour_p_first), .i_b (i_item.colour_p_second), .o_dist (w_dc_p)
    );
    ssc_dist_lane u_lane_cq (
        .i_clk (i_clk), .i_en (w_en),
        .i_a (i_item.colour_q_first), .i_b (i_item.colour_q_second), .o_dist (w_dc_q)
    );
    ssc_dist_lane u_lane_gp (
        .i_clk (i_clk), .i_en (w_en),
        .i_a (w_gp_first), .i_b (w_gp_second), .o_dist (w_dg_p)
    );
    ssc_dist_lane u_lane_gq (
        .i_clk (i_clk), .i_en (w_en),
        .i_a (w_gq_first), .i_b (w_gq_second), .o_dist (w_dg_q)
    );

    // Carry per-item side data alongside the lanes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 12; i++) begin
                r_vld_a[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld_a[0] <= i_item.valid;
            for (int i = 1; i < 12; i++) begin
                r_vld_a[i] <= r_vld_a[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pre[0] <= '{same: i_item.same_label, s: w_s};
            for (int i = 1; i < 12; i++) begin
                r_pre[i] <= r_pre[i-1];
            end
        end
    end

    // Merge lanes: colour and gradient sums, edge numerator 3*E*E.
    assign w_e  = {1'b0, w_dc_p} + {1'b0, w_dc_q};
    assign w_ee = w_e * w_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (w_en) begin
            r_m_vld <= r_vld_a[11];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_same <= r_pre[11].same;
            r_m_s    <= r_pre[11].s;
            r_m_e    <= w_e;
            r_m_g    <= {1'b0, w_dg_p} + {1'b0, w_dg_q};
            r_m_num  <= {w_ee, 1'b0} + {2'b00, w_ee};
        end
    end

    ssc_div u_div (
        .i_clk (i_clk), .i_en (w_en),
        .i_num (r_m_num), .i_den (r_m_s), .o_quo (w_quo)
    );

    ssc_isqrt u_edge_sqrt (
        .i_clk (i_clk), .i_en (w_en),
        .i_rad (w_quo), .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 33; i++) begin
                r_vld_b[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld_b[0] <= r_m_vld;
            for (int i = 1; i < 33; i++) begin
                r_vld_b[i] <= r_vld_b[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_post[0] <= '{same: r_m_same, szero: (r_m_s == 11'd0), e: r_m_e, g: r_m_g};
            for (int i = 1; i < 33; i++) begin
                r_post[i] <= r_post[i-1];
            end
        end
    end

    // Select the cost by mode; a shared label costs nothing.
    always_comb begin
        unique case (r_cost_mode)
            ssc_pkg::SSC_MODE_COLOUR: n_out_cost = {1'b0, r_post[32].e};
            ssc_pkg::SSC_MODE_GRAD:   n_out_cost = {1'b0, r_post[32].g};
            ssc_pkg::SSC_MODE_BOTH:   n_out_cost = {1'b0, r_post[32].e}
                                                 + {1'b0, r_post[32].g};
            ssc_pkg::SSC_MODE_EDGE:   n_out_cost = r_post[32].szero ? {1'b0, r_post[32].e}
                                                                    : w_root;
            default:                  n_out_cost = '0;
        endcase
        if (r_post[32].same) begin
            n_out_cost = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_vld_b[32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_cost <= n_out_cost;
        end
    end

    assign o_item.valid     = r_out_vld;
    assign o_item.seam_cost = r_out_cost;

    `SSC_ASSERT_SAME(a_lane_range, i_clk, i_rst_n, r_vld_a[11], (w_dc_p <= 9'd441) && (w_dg_q <= 9'd441), "lane distance out of range")
    `SSC_ASSERT_SAME(a_merge_range, i_clk, i_rst_n, r_m_vld, (r_m_e <= 10'd882) && (r_m_num <= 22'd2333772), "merge value out of range")
    `SSC_ASSERT_SAME(a_out_range, i_clk, i_rst_n, r_out_vld && (r_cost_mode != ssc_pkg::SSC_MODE_EDGE), r_out_cost <= 11'd1764, "cost above bound")
    `SSC_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !w_en, $stable(r_m_num) && $stable(r_out_cost), "pipeline moved while stalled")

endmodule

`default_nettype wire

// File: tb/seam_cost_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Seam cost checker
// Watches both channels, predicts each seam cost and compares in order.
// ----------------------------------------------------------------------------
module seam_cost_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    ssc_in_if           i_item,
    ssc_out_if          o_item,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    ssc_pkg::t_cost_mode mode_q;
    logic [10:0]         cost_queue[$];

    function automatic logic [31:0] floor_root(logic [31:0] v);
        logic [31:0] r;
        r = 0;
        for (int b = 15; b >= 0; b--) begin
            if ((r | (32'd1 << b)) * (r | (32'd1 << b)) <= v) r = r | (32'd1 << b);
        end
        return r;
    endfunction

    function automatic logic [31:0] triple_distance(logic [23:0] a, logic [23:0] b);
        logic [31:0] acc;
        int          d;
        acc = 0;
        for (int k = 0; k < 3; k++) begin
            d = int'(a[8*k +: 8]) - int'(b[8*k +: 8]);
            acc += d * d;
        end
        return floor_root(acc);
    endfunction

    function automatic logic [31:0] channel_sum(logic [23:0] a);
        return a[7:0] + a[15:8] + a[23:16];
    endfunction

    function automatic logic [10:0] predict_cost(ssc_pkg::t_cost_mode m);
        logic [23:0] gpf, gps, gqf, gqs;
        logic [31:0] cost, s;
        gpf = i_item.horizontal_pair ? i_item.grad_p_first[47:24]  : i_item.grad_p_first[23:0];
        gps = i_item.horizontal_pair ? i_item.grad_p_second[47:24] : i_item.grad_p_second[23:0];
        gqf = i_item.horizontal_pair ? i_item.grad_q_first[47:24]  : i_item.grad_q_first[23:0];
        gqs = i_item.horizontal_pair ? i_item.grad_q_second[47:24] : i_item.grad_q_second[23:0];
        cost = 0;
        if (!i_item.same_label) begin
            if (m != ssc_pkg::SSC_MODE_GRAD)
                cost = triple_distance(i_item.colour_p_first, i_item.colour_p_second)
                     + triple_distance(i_item.colour_q_first, i_item.colour_q_second);
            if (m == ssc_pkg::SSC_MODE_EDGE) begin
                s = channel_sum(gpf) + channel_sum(gps);
                if (s != 0) cost = floor_root((32'd3 * cost * cost) / s);
            end
            if (m == ssc_pkg::SSC_MODE_GRAD || m == ssc_pkg::SSC_MODE_BOTH)
                cost += triple_distance(gpf, gps) + triple_distance(gqf, gqs);
        end
        return cost[10:0];
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_checked = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        logic [10:0] want;
        if (!i_rst_n) begin
            mode_q <= ssc_pkg::SSC_MODE_COLOUR;
        end else begin
            if (i_cfg_we) mode_q <= ssc_pkg::t_cost_mode'(i_cfg_wdata);
            if (i_item.valid && i_item.ready) cost_queue = {cost_queue, predict_cost(mode_q)};
            if (o_item.valid && o_item.ready) begin
                o_checked++;
                if (cost_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected cost %0d", o_item.seam_cost));
                end else begin
                    want = cost_queue.pop_front();
                    if (want !== o_item.seam_cost)
                        report_mismatch($sformatf("seam_cost %0d, want %0d",
                                                  o_item.seam_cost, want));
                end
            end
        end
        o_pending = cost_queue.size();
    end
endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Seam smoothness cost testbench
// Drives neighbour pairs under every cost mode with random gaps and output
// stalls; a checker beside the block predicts and compares every cost.
// ----------------------------------------------------------------------------
module testbench;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_wdata;
    int         fail_count, pending, checked;
    int         sent;
    bit         calm;   // set during the stretch with no idling

    ssc_in_if  in_ch();
    ssc_out_if out_ch();

    seam_smoothness_cost_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata), .i_item(in_ch.sink), .o_item(out_ch.source)
    );

    seam_cost_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata), .i_item(in_ch), .o_item(out_ch),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    always begin
        i_clk = 1'b0; #1;
        i_clk = 1'b1; #1;
    end

    // Hard stop: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end

    // Stall the output at random, except during the calm stretch.
    always @(negedge i_clk) begin
        out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 14);
    end

    // Pack a gradient word, sometimes with extreme channels.
    function automatic logic [47:0] random_grad();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return {22'd0, 2'($urandom_range(3)), 22'd0, 2'($urandom_range(3))};
            default: return {16'($urandom()), $urandom()};
        endcase
    endfunction

    function automatic logic [23:0] random_colour();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return 24'($urandom());
        endcase
    endfunction

    // Offer one item and hold it until taken; idle first at random.
    task automatic send_pair(logic same, logic horiz, logic [23:0] cpf, logic [23:0] cps,
                             logic [23:0] cqf, logic [23:0] cqs, logic [47:0] gpf,
                             logic [47:0] gps, logic [47:0] gqf, logic [47:0] gqs);
        while (!calm && $urandom_range(99) < 14) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.same_label <= same;
        in_ch.horizontal_pair <= horiz;
        in_ch.colour_p_first <= cpf;
        in_ch.colour_p_second <= cps;
        in_ch.colour_q_first <= cqf;
        in_ch.colour_q_second <= cqs;
        in_ch.grad_p_first <= gpf;
        in_ch.grad_p_second <= gps;
        in_ch.grad_q_first <= gqf;
        in_ch.grad_q_second <= gqs;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic send_random();
        send_pair($urandom_range(7) == 0, 1'($urandom_range(1)), random_colour(),
                  random_colour(), random_colour(), random_colour(), random_grad(),
                  random_grad(), random_grad(), random_grad());
    endtask

    // Drain everything in flight, then write the mode.
    task automatic set_mode(ssc_pkg::t_cost_mode m);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int guard;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        calm = 1'b0;
        sent = 0;
        out_ch.ready = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.same_label = 1'b0;
        in_ch.horizontal_pair = 1'b0;
        in_ch.colour_p_first = '0;
        in_ch.colour_p_second = '0;
        in_ch.colour_q_first = '0;
        in_ch.colour_q_second = '0;
        in_ch.grad_p_first = '0;
        in_ch.grad_p_second = '0;
        in_ch.grad_q_first = '0;
        in_ch.grad_q_second = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: every mode at reset default and after writes, extremes,
        // same label, zero gradient sum in edge mode, small sums for large costs.
        for (int m = 0; m < 4; m++) begin
            if (m != 0) set_mode(ssc_pkg::t_cost_mode'(m));
            send_pair(0, 0, '0, '1, '0, '1, '1, '0, '1, '0);
            send_pair(0, 1, '1, '0, '1, '0, '0, '1, '0, '1);
            send_pair(1, 1, '1, '0, '0, '1, '1, '0, '1, '0);
            send_pair(0, 0, '1, '0, '1, '0, '0, '0, '0, '0);
            send_pair(0, 1, '0, '1, '0, '1, {24'd1, 24'd0}, '0, '0, '0);
            send_pair(0, 0, 24'h123456, 24'h123456, 24'h00ff00, 24'h00ff00,
                      48'h1, 48'h0, 48'h0, 48'h0);
        end

        // Random phases: a random mode each phase, edge mode in phases 1, 5 and 9, extremes included.
        for (int phase = 0; phase < 10; phase++) begin
            set_mode(ssc_pkg::t_cost_mode'(phase % 4 == 1 ? 3 : $urandom_range(3)));
            calm = (phase == 5);
            for (int k = 0; k < 102; k++) send_random();
        end
        calm = 1'b0;
        in_ch.valid <= 1'b0;

        guard = 0;
        while (pending != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (60) @(negedge i_clk);

        $display("Sent %0d neighbour pairs over all four cost modes; checked %0d costs.",
                 sent, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
